// ===== rtl/core/ksx_pkg.sv =====
// ----------------------------------------------------------------------------
// ksx_pkg
// Shared types and constants of the keyed stride XOR nibble cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package ksx_pkg;

    localparam int TABLE_LEN = 256;
    localparam int CHANNELS  = 16;

    localparam int POS_W = (TABLE_LEN > 1) ? $clog2(TABLE_LEN) : 1;
    localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_SET  = 2'd1,
        KIND_ENC  = 2'd2,
        KIND_DEC  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [POS_W-1:0] stride;
        logic [POS_W-1:0] send_pos;
        logic [POS_W-1:0] recv_pos;
    } chan_ent_t;

    localparam int CHAN_ENT_W = $bits(chan_ent_t);

    function automatic logic [7:0] nibble_swap(input logic [7:0] b);
        return {b[3:0], b[7:4]};
    endfunction

    function automatic logic [POS_W-1:0] advance(input logic [POS_W-1:0] pos,
                                                 input logic [POS_W-1:0] stride);
        logic [POS_W:0] sum;
        sum = {1'b0, pos} + {1'b0, stride};
        return POS_W'(sum % TABLE_LEN);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ksx_ram.sv =====
// ----------------------------------------------------------------------------
// ksx_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ksx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic                             re,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/keyed_stride_xor_nibble_cipher.sv =====
// ----------------------------------------------------------------------------
// keyed_stride_xor_nibble_cipher
// Per-channel byte stream cipher walking a key table with a channel stride.
// ----------------------------------------------------------------------------
// Takes one word per cycle and gives one result word per cycle when res_stall
// is low. A word is accepted into stage 1, which reads the channel state
// memory (stride, send and receive positions); stage 2 reads the key table
// at the selected position; the result lands in the output register. The
// channel state is written back as a word leaves stage 1, and a last-write
// bypass covers a word on the same channel right behind it. Load and set
// words give no result. Key table entries must be loaded before any encrypt
// or decrypt word uses them.
`default_nettype none

module keyed_stride_xor_nibble_cipher
    import ksx_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        valid,
    output logic             stall,
    input  wire logic [1:0]  kind,
    input  wire logic [3:0]  channel,
    input  wire logic [7:0]  data_byte,
    input  wire logic [7:0]  table_index,
    input  wire logic [15:0] key_step,
    input  wire logic        end_of_buffer,
    output logic             res_valid,
    input  wire logic        res_stall,
    output logic [7:0]       result_byte,
    output logic             end_of_buffer_res
);

    logic en1, en2, en_out, accept;

    // stage 1
    logic             s1_v_reg, s1_v_next;
    kind_t            s1_kind_reg;
    logic [CH_AW-1:0] s1_ch_reg;
    logic             s1_ch_ok_reg;
    logic [7:0]       s1_data_reg;
    logic [7:0]       s1_idx_reg;
    logic [15:0]      s1_step_reg;
    logic             s1_eob_reg;
    logic             s1_vld_reg;

    // stage 2
    logic             s2_v_reg, s2_v_next;
    logic             s2_enc_reg;
    logic [7:0]       s2_data_reg;
    logic             s2_eob_reg;

    // output
    logic             out_v_reg, out_v_next;
    logic [7:0]       out_byte_reg;
    logic             out_eob_reg;

    // channel state
    logic [CHANNELS-1:0] chan_vld_reg;
    logic                lw_v_reg;
    logic [CH_AW-1:0]    lw_ch_reg;
    chan_ent_t           lw_ent_reg;

    logic [CHAN_ENT_W-1:0] chan_rdata;
    chan_ent_t             ent, ent_next;
    logic                  chan_we;
    logic [POS_W-1:0]      pos;
    logic                  is_crypt;

    logic             tab_we, tab_re;
    logic [POS_W-1:0] tab_waddr;
    logic [7:0]       tab_rdata;
    logic [7:0]       res_calc;

    function automatic logic [15:0] key_step_mod(input logic [15:0] s);
        return 16'(s % TABLE_LEN);
    endfunction

    assign en_out = !out_v_reg || !res_stall;
    assign en2    = !s2_v_reg || en_out;
    assign en1    = !s1_v_reg || en2;
    assign stall  = !en1;
    assign accept = valid && en1;

    // stage 1: channel state lookup with bypass, update
    always_comb
    begin
        if (lw_v_reg && lw_ch_reg == s1_ch_reg)
        begin
            ent = lw_ent_reg;
        end
        else if (s1_vld_reg)
        begin
            ent = chan_ent_t'(chan_rdata);
        end
        else
        begin
            ent = '0;
        end

        is_crypt = (s1_kind_reg == KIND_ENC) || (s1_kind_reg == KIND_DEC);
        pos      = (s1_kind_reg == KIND_ENC) ? ent.send_pos : ent.recv_pos;
        ent_next = ent;

        unique case (s1_kind_reg)
            KIND_LOAD:
            begin
                ent_next = ent;
            end
            KIND_SET:
            begin
                ent_next.stride   = POS_W'(key_step_mod(s1_step_reg));
                ent_next.send_pos = '0;
                ent_next.recv_pos = '0;
            end
            KIND_ENC:
            begin
                ent_next.send_pos = advance(pos, ent.stride);
            end
            KIND_DEC:
            begin
                ent_next.recv_pos = advance(pos, ent.stride);
            end
            default:
            begin
                ent_next = ent;
            end
        endcase

        chan_we   = s1_v_reg && en2 && s1_ch_ok_reg && (s1_kind_reg != KIND_LOAD);
        tab_we    = s1_v_reg && en2 && (s1_kind_reg == KIND_LOAD)
                    && (32'(s1_idx_reg) < TABLE_LEN);
        tab_re    = s1_v_reg && en2 && s1_ch_ok_reg && is_crypt;
        tab_waddr = POS_W'(s1_idx_reg);

        s1_v_next = en1 ? valid : s1_v_reg;
        s2_v_next = en2 ? (s1_v_reg && s1_ch_ok_reg && is_crypt) : s2_v_reg;
    end

    // stage 2: key combine
    always_comb
    begin
        if (s2_enc_reg)
        begin
            res_calc = nibble_swap(s2_data_reg) ^ tab_rdata;
        end
        else
        begin
            res_calc = nibble_swap(s2_data_reg ^ tab_rdata);
        end
        out_v_next = en_out ? s2_v_reg : out_v_reg;
    end

    ksx_ram #(
        .WIDTH (CHAN_ENT_W),
        .DEPTH (CHANNELS)
    ) u_chan_ram (
        .clk   (clk),
        .we    (chan_we),
        .waddr (s1_ch_reg),
        .wdata (CHAN_ENT_W'(ent_next)),
        .re    (accept),
        .raddr (CH_AW'(channel)),
        .rdata (chan_rdata)
    );

    ksx_ram #(
        .WIDTH (8),
        .DEPTH (TABLE_LEN)
    ) u_key_ram (
        .clk   (clk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (s1_data_reg),
        .re    (tab_re),
        .raddr (pos),
        .rdata (tab_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
            out_v_reg    <= 1'b0;
            chan_vld_reg <= '0;
            lw_v_reg     <= 1'b0;
            s1_vld_reg   <= 1'b0;
        end
        else
        begin
            s1_v_reg  <= s1_v_next;
            s2_v_reg  <= s2_v_next;
            out_v_reg <= out_v_next;
            if (chan_we)
            begin
                chan_vld_reg[s1_ch_reg] <= 1'b1;
                lw_v_reg                <= 1'b1;
            end
            if (accept)
            begin
                s1_vld_reg <= chan_vld_reg[CH_AW'(channel)];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg  <= kind_t'(kind);
            s1_ch_reg    <= CH_AW'(channel);
            s1_ch_ok_reg <= (32'(channel) < CHANNELS);
            s1_data_reg  <= data_byte;
            s1_idx_reg   <= table_index;
            s1_step_reg  <= key_step;
            s1_eob_reg   <= end_of_buffer;
        end
        if (chan_we)
        begin
            lw_ch_reg  <= s1_ch_reg;
            lw_ent_reg <= ent_next;
        end
        if (s1_v_reg && en2)
        begin
            s2_enc_reg  <= (s1_kind_reg == KIND_ENC);
            s2_data_reg <= s1_data_reg;
            s2_eob_reg  <= s1_eob_reg;
        end
        if (s2_v_reg && en_out)
        begin
            out_byte_reg <= res_calc;
            out_eob_reg  <= s2_eob_reg;
        end
    end

    assign res_valid         = out_v_reg;
    assign result_byte       = out_byte_reg;
    assign end_of_buffer_res = out_eob_reg;

    a_no_stall_when_out_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        !out_v_reg |-> !stall
    ) else $error("input stalled with empty output register");

    a_chan_write_source: assert property (
        @(posedge clk) disable iff (!rst_n)
        chan_we |-> (s1_v_reg && s1_kind_reg != KIND_LOAD)
    ) else $error("channel state written without a set or crypt word");

    a_table_port_excl: assert property (
        @(posedge clk) disable iff (!rst_n)
        !(tab_we && tab_re)
    ) else $error("key table read and written by one word");

    a_result_lands: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s2_v_reg && en_out) |=> res_valid
    ) else $error("stage 2 word lost before output register");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench of the keyed stride XOR nibble cipher.
// A queue of words is built up front: a short directed set, then mostly
// stride set / buffer encrypt / buffer decrypt sequences with random content.
// Key table entries are loaded before any word reads them. A clocked driver
// offers the words with random gaps. An in-order scoreboard predicts each
// accepted word and checks every result word. The receiver stalls at random
// and holds off once for a long stretch so that the pipeline backs up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
    import ksx_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GEN_COPY  = 0;
    localparam int CHK_COPY  = 1;
    localparam int MAX_BURST = 12;
    localparam int LONG_HOLD = 300;

    typedef struct packed {
        kind_t       kind;
        logic [3:0]  channel;
        logic [7:0]  data;
        logic [7:0]  idx;
        logic [15:0] step;
        logic        eob;
    } cipher_word_t;

    typedef struct packed {
        logic [7:0] value;
        logic       eob;
    } cipher_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        valid = 1'b0;
    logic        stall;
    kind_t       kind = KIND_LOAD;
    logic [3:0]  channel = '0;
    logic [7:0]  data_byte = '0;
    logic [7:0]  table_index = '0;
    logic [15:0] key_step = '0;
    logic        end_of_buffer = 1'b0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [7:0]  result_byte;
    logic        end_of_buffer_res;

    keyed_stride_xor_nibble_cipher u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .valid             (valid),
        .stall             (stall),
        .kind              (kind),
        .channel           (channel),
        .data_byte         (data_byte),
        .table_index       (table_index),
        .key_step          (key_step),
        .end_of_buffer     (end_of_buffer),
        .res_valid         (res_valid),
        .res_stall         (res_stall),
        .result_byte       (result_byte),
        .end_of_buffer_res (end_of_buffer_res)
    );

    always #6 clk = ~clk;

    // two copies of the cipher state: one walked while building the stream,
    // one walked as words are accepted
    logic [7:0] key_tbl    [2][TABLE_LEN];
    int         stride_mem [2][CHANNELS];
    int         send_mem   [2][CHANNELS];
    int         recv_mem   [2][CHANNELS];
    bit         tbl_loaded [TABLE_LEN];

    cipher_word_t word_q[$];
    cipher_res_t  expected_q[$];
    cipher_word_t cur_word;

    int  fail_cnt = 0;
    int  tx_gap = 0;
    int  rx_gap = 0;
    int  hold_cnt = 0;
    int  results_seen = 0;
    bit  hold_done = 1'b0;
    bit  quiet = 1'b0;
    bit  all_sent = 1'b0;

    function automatic bit cipher_apply(input int c, input cipher_word_t w,
                                        output cipher_res_t r);
        int p;
        r = '0;
        if (w.kind == KIND_LOAD)
        begin
            if (int'(w.idx) < TABLE_LEN)
                key_tbl[c][w.idx] = w.data;
            return 1'b0;
        end
        if (int'(w.channel) >= CHANNELS)
            return 1'b0;
        case (w.kind)
            KIND_SET:
            begin
                stride_mem[c][w.channel] = int'(w.step) % TABLE_LEN;
                send_mem[c][w.channel] = 0;
                recv_mem[c][w.channel] = 0;
                return 1'b0;
            end
            KIND_ENC:
            begin
                p = send_mem[c][w.channel];
                r.value = {w.data[3:0], w.data[7:4]} ^ key_tbl[c][p];
                send_mem[c][w.channel] = (p + stride_mem[c][w.channel]) % TABLE_LEN;
            end
            default:
            begin
                p = recv_mem[c][w.channel];
                r.value = w.data ^ key_tbl[c][p];
                r.value = {r.value[3:0], r.value[7:4]};
                recv_mem[c][w.channel] = (p + stride_mem[c][w.channel]) % TABLE_LEN;
            end
        endcase
        r.eob = w.eob;
        return 1'b1;
    endfunction

    function automatic cipher_word_t rand_word(input kind_t k);
        cipher_word_t w;
        w.kind    = k;
        w.channel = 4'($urandom);
        w.data    = 8'($urandom);
        w.idx     = 8'($urandom);
        w.step    = 16'($urandom);
        w.eob     = 1'($urandom);
        return w;
    endfunction

    task automatic push_word(input cipher_word_t w, output cipher_res_t r);
        void'(cipher_apply(GEN_COPY, w, r));
        if (w.kind == KIND_LOAD)
            tbl_loaded[w.idx] = 1'b1;
        word_q.push_back(w);
    endtask

    task automatic push_load(input logic [7:0] idx, input logic [7:0] data);
        cipher_word_t w;
        cipher_res_t  r;
        w = rand_word(KIND_LOAD);
        w.idx  = idx;
        w.data = data;
        push_word(w, r);
    endtask

    task automatic push_set(input logic [3:0] ch, input logic [15:0] step);
        cipher_word_t w;
        cipher_res_t  r;
        w = rand_word(KIND_SET);
        w.channel = ch;
        w.step    = step;
        push_word(w, r);
    endtask

    // loads the key byte first if the walk lands on an unloaded entry
    task automatic push_crypt(input kind_t k, input logic [3:0] ch,
                              input logic [7:0] data, input logic eob,
                              output cipher_res_t r);
        cipher_word_t w;
        int p;
        p = (k == KIND_ENC) ? send_mem[GEN_COPY][ch] : recv_mem[GEN_COPY][ch];
        if (!tbl_loaded[p])
            push_load(8'(p), 8'($urandom));
        w = rand_word(k);
        w.channel = ch;
        w.data    = data;
        w.eob     = eob;
        push_word(w, r);
    endtask

    task automatic build_stream();
        cipher_res_t r;
        logic [7:0]  ct [MAX_BURST];
        logic        last;
        logic [3:0]  ch;
        int          n;
        int          sel;

        // directed: table ends, zero / full strides, data extremes
        push_load(8'h00, 8'h00);
        push_load(8'hFF, 8'hFF);
        push_load(8'h80, 8'hA5);
        push_set(4'd0, 16'h0000);
        push_crypt(KIND_ENC, 4'd0, 8'h00, 1'b0, r);
        push_crypt(KIND_ENC, 4'd0, 8'hFF, 1'b1, r);
        push_crypt(KIND_DEC, 4'd0, 8'h5A, 1'b0, r);
        push_load(8'h00, 8'h3C);
        push_crypt(KIND_DEC, 4'd0, 8'hFF, 1'b1, r);
        push_set(4'd15, 16'hFFFF);
        push_crypt(KIND_ENC, 4'd15, 8'h12, 1'b0, r);
        push_crypt(KIND_ENC, 4'd15, 8'hF0, 1'b0, r);
        push_crypt(KIND_ENC, 4'd15, 8'h0F, 1'b1, r);
        push_crypt(KIND_DEC, 4'd15, 8'hC3, 1'b0, r);
        push_crypt(KIND_DEC, 4'd15, 8'h00, 1'b1, r);
        push_set(4'd3, 16'h0100);
        push_crypt(KIND_ENC, 4'd3, 8'h7E, 1'b1, r);
        push_set(4'd7, 16'h8001);
        push_crypt(KIND_ENC, 4'd7, 8'h81, 1'b0, r);
        push_crypt(KIND_ENC, 4'd7, 8'h18, 1'b1, r);
        push_crypt(KIND_DEC, 4'd7, 8'hFF, 1'b0, r);
        push_crypt(KIND_DEC, 4'd7, 8'h00, 1'b1, r);

        while (word_q.size() < 700)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 7)
            begin
                ch = 4'($urandom);
                if ($urandom_range(0, 3) != 0)
                    push_set(ch, 16'($urandom));
                n = $urandom_range(1, MAX_BURST);
                for (int i = 0; i < n; i++)
                begin
                    last = (i == n - 1);
                    push_crypt(KIND_ENC, ch, 8'($urandom), last, r);
                    ct[i] = r.value;
                end
                if ($urandom_range(0, 1) != 0)
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        last = (i == n - 1);
                        push_crypt(KIND_DEC, ch, ct[i], last, r);
                    end
                end
            end
            else if (sel < 9)
            begin
                push_load(8'($urandom), 8'($urandom));
            end
            else
            begin
                push_crypt(($urandom_range(0, 1) != 0) ? KIND_ENC : KIND_DEC,
                           4'($urandom), 8'($urandom), 1'($urandom), r);
            end
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin : drv
        cipher_word_t w;
        cipher_res_t  r;
        if (!rst_n)
        begin
            valid    <= 1'b0;
            tx_gap   <= 0;
            all_sent <= 1'b0;
            quiet    <= 1'b0;
        end
        else
        begin
            if (valid && !stall)
            begin
                if (cipher_apply(CHK_COPY, cur_word, r))
                    expected_q.push_back(r);
            end
            quiet <= (word_q.size() < 80);
            if (!valid || !stall)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap <= tx_gap - 1;
                    valid  <= 1'b0;
                end
                else if (word_q.size() == 0)
                begin
                    valid    <= 1'b0;
                    all_sent <= 1'b1;
                end
                else if (!quiet && $urandom_range(0, 9) == 0)
                begin
                    tx_gap <= $urandom_range(0, 15);
                    valid  <= 1'b0;
                end
                else
                begin
                    w = word_q.pop_front();
                    cur_word      <= w;
                    kind          <= w.kind;
                    channel       <= w.channel;
                    data_byte     <= w.data;
                    table_index   <= w.idx;
                    key_step      <= w.step;
                    end_of_buffer <= w.eob;
                    valid         <= 1'b1;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin : mon
        cipher_res_t e;
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            rx_gap    <= 0;
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                results_seen <= results_seen + 1;
                if (expected_q.size() == 0)
                begin
                    fail_cnt = fail_cnt + 1;
                    $display("%0t: unexpected word result_byte=%02h eob=%0b",
                             $time, result_byte, end_of_buffer_res);
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (result_byte !== e.value)
                    begin
                        fail_cnt = fail_cnt + 1;
                        $display("%0t: result_byte expected %02h actual %02h",
                                 $time, e.value, result_byte);
                    end
                    if (end_of_buffer_res !== e.eob)
                    begin
                        fail_cnt = fail_cnt + 1;
                        $display("%0t: end_of_buffer_res expected %0b actual %0b",
                                 $time, e.eob, end_of_buffer_res);
                    end
                end
            end
            if (hold_cnt > 0)
            begin
                hold_cnt  <= hold_cnt - 1;
                res_stall <= 1'b1;
            end
            else if (!hold_done && results_seen >= 150)
            begin
                hold_cnt  <= LONG_HOLD - 1;
                hold_done <= 1'b1;
                res_stall <= 1'b1;
            end
            else if (rx_gap > 0)
            begin
                rx_gap    <= rx_gap - 1;
                res_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                rx_gap    <= $urandom_range(0, 15);
                res_stall <= 1'b1;
            end
            else
            begin
                res_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        for (int c = 0; c < 2; c++)
        begin
            for (int i = 0; i < TABLE_LEN; i++)
                key_tbl[c][i] = '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                stride_mem[c][i] = 0;
                send_mem[c][i]   = 0;
                recv_mem[c][i]   = 0;
            end
        end
        for (int i = 0; i < TABLE_LEN; i++)
            tbl_loaded[i] = 1'b0;
        build_stream();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (all_sent);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (fail_cnt == 0 && expected_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
